[rtl/core/multi_servo_slew_limiter_top_macros.svh]
// Assertion macros shared by the slew limiter checker.
`ifndef MULTI_SERVO_SLEW_LIMITER_TOP_MACROS_SVH
`define MULTI_SERVO_SLEW_LIMITER_TOP_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define MSL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define MSL_ASSERT(lbl, prop, msg) `MSL_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)

`endif

[rtl/core/msl_pkg.sv]
// Shared types, codes and constants of the servo slew limiter.
`default_nettype none

package msl_pkg;

    localparam int MAX_SERVOS_DEF = 16;
    localparam int RESULT_CAP     = 16;

    localparam int REQ_W    = 3;
    localparam int IDX_IN_W = 4;
    localparam int DEG_W    = 11;
    localparam int ANGLE_W  = 15;
    localparam int LIVE_W   = 5;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 24;

    localparam logic [REQ_W-1:0] REQ_SET    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_STOP   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CENTER = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    localparam logic KIND_POS  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_STEP   = 1'b1;

    localparam logic [ANGLE_W-1:0] CENTER_ANGLE = 15'd9000;
    localparam logic [ANGLE_W-1:0] FULL_ANGLE   = 15'd18000;
    localparam logic [ANGLE_W-1:0] STEP_RESET   = 15'd180;
    localparam logic [ANGLE_W-1:0] DEG_SCALE    = 15'd100;
    localparam logic [7:0]         DEG_LIMIT    = 8'd180;

    typedef struct packed {
        logic accept;
        logic pass_step;
        logic emit_load;
        logic read_load;
    } msl_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] op;
        logic             n_zero;
        logic             pass_last;
        logic             have_results;
        logic             emit_last;
        logic             out_free;
    } msl_status_t;

endpackage

`default_nettype wire

[rtl/core/multi_servo_slew_limiter_top.sv]
// Top level of the multichannel servo slew-rate limiter.
//
//  channel   direction  tdata                                     tuser         tlast
//  s_        in         [3:0] servo_index, [14:4] target_angle     [2:0] req_type  -
//  m_        out        [3:0] out_index, [18:4] angle_out,         [0] result_kind last
//                       [19] index_valid, [20] any_moving
//  cfg_      in         cfg_addr 0 active_servos, 1 step_size      -             -
//
// Set and unused codes end at acceptance; stop-all and center-all add a pass over the
// live channels; a read adds the pass and then its reply; a tick adds the pass and then
// one result per channel that moved. The pass walks the live channels one channel a cycle
// through the single read port of the angle stores (the scan also gathers the moving flag).
// Reset clears both angle stores to centre; no clearing pass.
// A stalled result holds the sequencer; only an item's last result waits on alone.
`default_nettype none

module multi_servo_slew_limiter_top #(
    parameter int MAX_SERVOS = msl_pkg::MAX_SERVOS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration write port
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [msl_pkg::ANGLE_W-1:0]  cfg_wdata,
    // request items
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [msl_pkg::IN_W-1:0]     s_tdata,   // servo_index, target_angle
    input  wire logic [msl_pkg::REQ_W-1:0]    s_tuser,   // req_type
    // result items
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [msl_pkg::OUT_W-1:0]         m_tdata,   // out_index, angle_out,
                                                         // index_valid, any_moving
    output logic                              m_tuser,   // result_kind
    output logic                              m_tlast    // last
);

    msl_pkg::msl_cmd_t    cmd;
    msl_pkg::msl_status_t status;

    // sequence each request: accept, walk the channels, then hand out results
    msl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    // hold the angles, step them, buffer position writes and drive the output
    msl_datapath #(
        .MAX_SERVOS (MAX_SERVOS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .req_type     (s_tuser),
        .servo_index  (s_tdata[3:0]),
        .target_angle (s_tdata[14:4]),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/core/msl_ctrl.sv]
// Request sequencer of the servo slew limiter.
`default_nettype none

module msl_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [msl_pkg::REQ_W-1:0]   req_type,
    input  wire msl_pkg::msl_status_t        status,
    output msl_pkg::msl_cmd_t                cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_READ = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready      = (state_reg == ST_IDLE);
    assign cmd.accept    = s_tvalid && s_tready;
    assign cmd.pass_step = (state_reg == ST_PASS);
    assign cmd.emit_load = (state_reg == ST_EMIT) && status.out_free;
    assign cmd.read_load = (state_reg == ST_READ) && status.out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    unique case (req_type) inside
                        msl_pkg::REQ_TICK, msl_pkg::REQ_STOP, msl_pkg::REQ_CENTER: begin
                            state_next = status.n_zero ? ST_IDLE : ST_PASS;
                        end
                        msl_pkg::REQ_READ: begin
                            state_next = status.n_zero ? ST_READ : ST_PASS;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PASS: begin
                if (status.pass_last) begin
                    if (status.op == msl_pkg::REQ_TICK) begin
                        state_next = status.have_results ? ST_EMIT : ST_IDLE;
                    end else if (status.op == msl_pkg::REQ_READ) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/msl_datapath.sv]
// Angle stores, step unit, result buffer and output register of the slew limiter.
`default_nettype none

module msl_datapath #(
    parameter int MAX_SERVOS = msl_pkg::MAX_SERVOS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_addr,
    input  wire logic [msl_pkg::ANGLE_W-1:0]         cfg_wdata,
    input  wire logic [msl_pkg::REQ_W-1:0]           req_type,
    input  wire logic [msl_pkg::IDX_IN_W-1:0]        servo_index,
    input  wire logic signed [msl_pkg::DEG_W-1:0]    target_angle,
    input  wire msl_pkg::msl_cmd_t                   cmd,
    output msl_pkg::msl_status_t                     status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [msl_pkg::OUT_W-1:0]                m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast
);

    localparam int DEPTH = (MAX_SERVOS < msl_pkg::RESULT_CAP) ? MAX_SERVOS
                                                               : msl_pkg::RESULT_CAP;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int AW    = msl_pkg::ANGLE_W;
    localparam int LW    = msl_pkg::LIVE_W;
    localparam logic [LW-1:0] DEPTH_N = LW'(DEPTH);

    // configuration
    logic [LW-1:0] active_reg;
    logic [AW-1:0] step_reg;

    // angle stores
    logic [AW-1:0] cur_reg [DEPTH];
    logic [AW-1:0] tgt_reg [DEPTH];

    // pass control
    logic [msl_pkg::REQ_W-1:0] op_reg;
    logic [IDX_W-1:0]          pass_cnt_reg;
    logic [CNT_W-1:0]          wr_cnt_reg;
    logic [IDX_W-1:0]          rd_ptr_reg;
    logic                      moving_reg;

    // result buffer and read reply
    logic [IDX_W-1:0]             buf_idx_reg [DEPTH];
    logic [AW-1:0]                buf_ang_reg [DEPTH];
    logic                         rd_valid_reg;
    logic [AW-1:0]                rd_angle_reg;
    logic [msl_pkg::IDX_IN_W-1:0] rd_index_reg;

    // output register
    logic                         m_valid_reg;
    logic                         m_kind_reg;
    logic [msl_pkg::IDX_IN_W-1:0] m_index_reg;
    logic [AW-1:0]                m_angle_reg;
    logic                         m_ivalid_reg;
    logic                         m_moving_reg;
    logic                         m_last_reg;

    logic [LW-1:0]    n_live;
    logic [IDX_W-1:0] rd_addr;
    logic [AW-1:0]    cur_rd;
    logic [AW-1:0]    tgt_rd;
    logic             up;
    logic [AW-1:0]    span;
    logic [AW:0]      sum;
    logic [AW-1:0]    stepped;
    logic             differs;
    logic             push;
    logic [AW-1:0]    pass_cur;
    logic             idx_live;
    logic [7:0]       deg_clamped;
    logic [AW-1:0]    set_angle;
    logic             out_free;

    assign n_live   = (active_reg > DEPTH_N) ? DEPTH_N : active_reg;
    assign rd_addr  = cmd.pass_step ? pass_cnt_reg : servo_index[IDX_W-1:0];
    assign cur_rd   = cur_reg[rd_addr];
    assign tgt_rd   = tgt_reg[pass_cnt_reg];

    // step toward the target, snap when within one step
    assign up   = (tgt_rd > cur_rd);
    assign span = up ? (tgt_rd - cur_rd) : (cur_rd - tgt_rd);
    assign sum  = {1'b0, cur_rd} + {1'b0, step_reg};

    always_comb begin
        if (span <= step_reg) begin
            stepped = tgt_rd;
        end else if (up) begin
            stepped = (sum > {1'b0, msl_pkg::FULL_ANGLE}) ? msl_pkg::FULL_ANGLE : sum[AW-1:0];
        end else begin
            stepped = cur_rd - step_reg;
        end
    end

    assign differs  = (cur_rd != tgt_rd);
    assign push     = cmd.pass_step && (op_reg == msl_pkg::REQ_TICK) && differs;
    assign pass_cur = (op_reg == msl_pkg::REQ_TICK) ? stepped : cur_rd;
    assign idx_live = ({1'b0, servo_index} < n_live);

    always_comb begin
        if (target_angle < 0) begin
            deg_clamped = 8'd0;
        end else if (target_angle > $signed({3'b000, msl_pkg::DEG_LIMIT})) begin
            deg_clamped = msl_pkg::DEG_LIMIT;
        end else begin
            deg_clamped = target_angle[7:0];
        end
    end

    assign set_angle = AW'(deg_clamped) * msl_pkg::DEG_SCALE;
    assign out_free  = !m_valid_reg || m_tready;

    assign status.op           = op_reg;
    assign status.n_zero       = (n_live == '0);
    assign status.pass_last    = ((LW'(pass_cnt_reg) + LW'(1)) == n_live);
    assign status.have_results = (wr_cnt_reg != '0) || push;
    assign status.emit_last    = ((LW'(rd_ptr_reg) + LW'(1)) == LW'(wr_cnt_reg));
    assign status.out_free     = out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= '0;
            step_reg     <= msl_pkg::STEP_RESET;
            op_reg       <= msl_pkg::REQ_SET;
            pass_cnt_reg <= '0;
            wr_cnt_reg   <= '0;
            rd_ptr_reg   <= '0;
            moving_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                cur_reg[i] <= msl_pkg::CENTER_ANGLE;
                tgt_reg[i] <= msl_pkg::CENTER_ANGLE;
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    msl_pkg::CFG_ACTIVE: active_reg <= cfg_wdata[LW-1:0];
                    msl_pkg::CFG_STEP:   step_reg   <= cfg_wdata;
                endcase
            end

            if (cmd.accept) begin
                op_reg       <= req_type;
                pass_cnt_reg <= '0;
                wr_cnt_reg   <= '0;
                rd_ptr_reg   <= '0;
                moving_reg   <= 1'b0;
                if ((req_type == msl_pkg::REQ_SET) && idx_live) begin
                    tgt_reg[servo_index[IDX_W-1:0]] <= set_angle;
                end
            end

            if (cmd.pass_step) begin
                pass_cnt_reg <= pass_cnt_reg + IDX_W'(1);
                moving_reg   <= moving_reg || (pass_cur != tgt_rd);
                unique case (op_reg)
                    msl_pkg::REQ_TICK: begin
                        if (differs) begin
                            cur_reg[pass_cnt_reg] <= stepped;
                        end
                    end
                    msl_pkg::REQ_STOP:   tgt_reg[pass_cnt_reg] <= cur_rd;
                    msl_pkg::REQ_CENTER: tgt_reg[pass_cnt_reg] <= msl_pkg::CENTER_ANGLE;
                    default: begin
                    end
                endcase
            end

            if (push) begin
                wr_cnt_reg <= wr_cnt_reg + CNT_W'(1);
            end

            if (cmd.emit_load) begin
                rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
            end

            if (cmd.emit_load || cmd.read_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_idx_reg[wr_cnt_reg[IDX_W-1:0]] <= pass_cnt_reg;
            buf_ang_reg[wr_cnt_reg[IDX_W-1:0]] <= stepped;
        end

        if (cmd.accept) begin
            rd_valid_reg <= idx_live;
            rd_angle_reg <= idx_live ? cur_rd : '0;
            rd_index_reg <= servo_index;
        end

        if (cmd.emit_load) begin
            m_kind_reg   <= msl_pkg::KIND_POS;
            m_index_reg  <= msl_pkg::IDX_IN_W'(buf_idx_reg[rd_ptr_reg]);
            m_angle_reg  <= buf_ang_reg[rd_ptr_reg];
            m_ivalid_reg <= 1'b1;
            m_moving_reg <= moving_reg;
            m_last_reg   <= status.emit_last;
        end else if (cmd.read_load) begin
            m_kind_reg   <= msl_pkg::KIND_READ;
            m_index_reg  <= rd_index_reg;
            m_angle_reg  <= rd_angle_reg;
            m_ivalid_reg <= rd_valid_reg;
            m_moving_reg <= moving_reg;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_moving_reg, m_ivalid_reg, m_angle_reg, m_index_reg};

endmodule

`default_nettype wire

[rtl/core/msl_checker.sv]
// Port-level checks of the slew limiter and their binding to the top level.
`default_nettype none
`include "multi_servo_slew_limiter_top_macros.svh"

module msl_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [msl_pkg::OUT_W-1:0]    m_tdata,
    input wire logic                         m_tuser,
    input wire logic                         m_tlast
);

    logic [msl_pkg::OUT_W+1:0]   beat;
    logic                        stall;
    logic                        is_read;
    logic                        ivalid;
    logic [msl_pkg::ANGLE_W-1:0] angle;
    logic                        angle_ok;

    assign beat     = {m_tlast, m_tuser, m_tdata};
    assign stall    = m_tvalid && !m_tready;
    assign is_read  = (m_tuser == msl_pkg::KIND_READ);
    assign ivalid   = m_tdata[19];
    assign angle    = m_tdata[18:4];
    assign angle_ok = (angle <= msl_pkg::FULL_ANGLE) && (ivalid || (angle == '0));

    // a stalled result holds still
    `MSL_ASSERT(a_hold, stall |=> (m_tvalid && $stable(beat)), "result changed under stall")

    // a read reply is always the only result of its item
    `MSL_ASSERT(a_read_last, (m_tvalid && is_read) |-> m_tlast, "read reply without last")

    // position writes always concern a live channel
    `MSL_ASSERT(a_pos_valid, (m_tvalid && !is_read) |-> ivalid, "position write invalid")

    // angles stay inside the travel, invalid reads carry zero
    `MSL_ASSERT(a_angle, m_tvalid |-> angle_ok, "angle out of range")

endmodule

bind multi_servo_slew_limiter_top msl_checker u_msl_checker (.*);

`default_nettype wire
